// File: hdl/vlrr_pkg.sv
// vlrr_pkg: shared types and codes of the variable length request ring
// item structs, op and status codes, controller states, buffer handshake structs
// no dependencies
`timescale 1ns / 1ps

package vlrr_pkg;

	localparam int WORD_W  = 64;
	localparam int PLEN_W  = 9;
	localparam int CFG_W   = 10;
	localparam int BYTES_W = 9;

	localparam logic [1:0] OP_BEGIN   = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_DRAIN   = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOROOM   = 3'd1;
	localparam logic [2:0] ST_PROTO    = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NOTREADY = 3'd4;
	localparam logic [2:0] ST_WORD     = 3'd5;

	localparam logic [CFG_W-1:0] MAX_ADVANCE_RESET = 10'd512;

	typedef struct packed {
		logic [1:0]        op;
		logic [PLEN_W-1:0] payload_bytes;
		logic [WORD_W-1:0] data_word;
	} req_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [WORD_W-1:0]  word_out;
		logic               last;
		logic [BYTES_W-1:0] drained_bytes;
	} rsp_item_t;

	typedef enum logic {
		CTRL_IDLE,
		CTRL_DRAIN
	} ctrl_state_t;

	// read issued toward the ring memory during a drain
	typedef struct packed {
		logic               issue;
		logic               last;
		logic [BYTES_W-1:0] drained_bytes;
	} rd_issue_t;

	// output buffer status back to the controller
	typedef struct packed {
		logic single_ok;
		logic read_room;
	} obuf_stat_t;

endpackage

// File: hdl/variable_length_request_ring.sv
// variable_length_request_ring: top level of the framed request ring
// ties vlrr_ctrl, vlrr_ring_mem and vlrr_out_buf together; uses vlrr_pkg
//
// usage:
//   req channel (req_valid/req_ready/req) takes begin, payload and drain items.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns the results in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes max_advance_bytes; it is
//   always ready; the user must see it is written only while the ring is idle;
//   the block itself does not enforce this.
// results and throughput:
//   begin, payload and failed drains give one result, registered, in the cycle
//   after the transfer; a new item is taken every cycle while no drain runs and
//   rsp keeps up. a drain reads via the state, ring memory read and result
//   registers, then gives one word per cycle while rsp keeps up; the next item
//   is taken once the last word sits in the result register.
// reset:
//   pointers, open request and limit (512) clear at once; the ring memory is
//   not cleared and no sweep runs.
// stalls:
//   a result waits in the result register, and a drained word in flight goes to
//   a one-entry skid; memory reads pause until there is room.
`timescale 1ns / 1ps

module variable_length_request_ring #(
	parameter int RING_BYTES = 512
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  vlrr_pkg::req_item_t        req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output vlrr_pkg::rsp_item_t        rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [vlrr_pkg::CFG_W-1:0] cfg_data
);
	import vlrr_pkg::*;

	localparam int RING_WORDS = RING_BYTES / 8;
	localparam int AW         = $clog2(RING_WORDS);

	obuf_stat_t        stat;
	logic              single_valid;
	rsp_item_t         single;
	rd_issue_t         rd;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	vlrr_ctrl #(
		.RING_BYTES(RING_BYTES),
		.AW        (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.stat        (stat),
		.single_valid(single_valid),
		.single      (single),
		.rd          (rd),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr)
	);

	vlrr_ring_mem #(
		.DEPTH(RING_WORDS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	vlrr_out_buf u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.single_valid(single_valid),
		.single      (single),
		.rd          (rd),
		.rdata       (mem_rdata),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.stat        (stat)
	);

endmodule

// File: hdl/vlrr_ring_mem.sv
// vlrr_ring_mem: single-port-write, single-port-read ring word store
// read data registered; uses vlrr_pkg for the word width
`timescale 1ns / 1ps

module vlrr_ring_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [vlrr_pkg::WORD_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [vlrr_pkg::WORD_W-1:0] rdata
);
	import vlrr_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/vlrr_out_buf.sv
// vlrr_out_buf: result register with a one-entry skid for drained words
// tracks the memory read in flight; uses vlrr_pkg item and status structs
`timescale 1ns / 1ps

module vlrr_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        single_valid,
	input  vlrr_pkg::rsp_item_t         single,
	input  vlrr_pkg::rd_issue_t         rd,
	input  logic [vlrr_pkg::WORD_W-1:0] rdata,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output vlrr_pkg::rsp_item_t         rsp,
	output vlrr_pkg::obuf_stat_t        stat
);
	import vlrr_pkg::*;

	logic               out_valid_q;
	rsp_item_t          out_q;
	logic               skid_valid_q;
	rsp_item_t          skid_q;
	logic               pend_s1;
	logic               pend_last_s1;
	logic [BYTES_W-1:0] pend_bytes_s1;

	logic      take;
	logic      out_free;
	rsp_item_t rd_item;
	logic [1:0] occ;

	assign take     = out_valid_q && rsp_ready;
	assign out_free = !out_valid_q || take;

	always_comb begin
		rd_item.status        = ST_WORD;
		rd_item.word_out      = rdata;
		rd_item.last          = pend_last_s1;
		rd_item.drained_bytes = pend_bytes_s1;
	end

	// entries held or on the way, less the one leaving now
	assign occ = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(pend_s1) - 2'(take);

	assign stat.single_ok = out_free && !skid_valid_q && !pend_s1;
	assign stat.read_room = (occ <= 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			pend_s1      <= 1'b0;
		end else begin
			pend_s1 <= rd.issue;
			if (out_free) begin
				out_valid_q <= skid_valid_q || pend_s1 || single_valid;
			end
			if (skid_valid_q && out_free) begin
				skid_valid_q <= pend_s1;
			end else if (pend_s1 && !out_free) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_last_s1  <= rd.last;
		pend_bytes_s1 <= rd.drained_bytes;
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (pend_s1) begin
				out_q <= rd_item;
			end else begin
				out_q <= single;
			end
		end
		// read data lands in the skid when it cannot go straight out
		if (pend_s1 && (skid_valid_q || !out_free)) begin
			skid_q <= rd_item;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: hdl/vlrr_ctrl.sv
// vlrr_ctrl: ring pointers, admission check, payload placement and drain sequencer
// drives the ring memory and the output buffer; uses vlrr_pkg
`timescale 1ns / 1ps

module vlrr_ctrl #(
	parameter int RING_BYTES = 512,
	parameter int AW         = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  vlrr_pkg::req_item_t         req,
	input  logic                        cfg_valid,
	input  logic [vlrr_pkg::CFG_W-1:0]  cfg_data,
	input  vlrr_pkg::obuf_stat_t        stat,
	output logic                        single_valid,
	output vlrr_pkg::rsp_item_t         single,
	output vlrr_pkg::rd_issue_t         rd,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [vlrr_pkg::WORD_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr
);
	import vlrr_pkg::*;

	localparam int RING_WORDS = RING_BYTES / 8;

	ctrl_state_t        state_q, state_d;
	logic [AW-1:0]      prod_q, cons_q, prog_q, idx_q;
	logic               open_q;
	logic [PLEN_W-1:0]  rem_q;
	logic [CFG_W-1:0]   max_adv_q;
	logic [AW:0]        cnt_q;
	logic [BYTES_W-1:0] bytes_q;

	logic               accept;
	logic [AW:0]        gap;
	logic [10:0]        used;
	logic [9:0]         req_bytes;
	logic               no_room;
	logic [7:0]         prod_sum;
	logic [AW-1:0]      prod_new;
	logic [9:0]         rem_round;
	logic [7:0]         wl8;
	logic [7:0]         slot8;
	logic [WORD_W-1:0]  masked;
	logic [PLEN_W-1:0]  rem_new;
	logic [AW:0]        count;
	logic [11:0]        count_bytes;
	logic [AW-1:0]      idx_next;
	logic               drain_go;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == CTRL_IDLE) && stat.single_ok;

	// forward distance consumer to producer, in words
	always_comb begin
		if (prod_q >= cons_q) begin
			gap = {1'b0, prod_q} - {1'b0, cons_q};
		end else begin
			gap = {1'b0, prod_q} + (AW + 1)'(RING_WORDS) - {1'b0, cons_q};
		end
		used      = 11'(gap) << 3;
		req_bytes = ({1'b0, req.payload_bytes} + 10'd15) & ~10'd7;
		no_room   = (used + 11'(req_bytes) >= 11'(max_adv_q))
			|| (11'(req_bytes) > 11'(RING_BYTES) - used);
		prod_sum  = 8'(prod_q) + 8'(req_bytes[9:3]);
		if (prod_sum >= 8'(RING_WORDS)) begin
			prod_new = AW'(prod_sum - 8'(RING_WORDS));
		end else begin
			prod_new = AW'(prod_sum);
		end
	end

	// slot of the next payload word, counted back from the producer
	always_comb begin
		rem_round = {1'b0, rem_q} + 10'd7;
		wl8       = {1'b0, rem_round[9:3]};
		if (8'(prod_q) >= wl8) begin
			slot8 = 8'(prod_q) - wl8;
		end else begin
			slot8 = 8'(prod_q) + 8'(RING_WORDS) - wl8;
		end
		masked = req.data_word;
		if (rem_q < 9'd8) begin
			for (int b = 0; b < 8; b++) begin
				if (3'(b) >= rem_q[2:0]) begin
					masked[b*8 +: 8] = 8'h00;
				end
			end
			rem_new = '0;
		end else begin
			rem_new = rem_q - 9'd8;
		end
	end

	always_comb begin
		count = (gap == '0) ? (AW + 1)'(RING_WORDS) : gap;
		count_bytes = 12'(count) << 3;
		if (idx_q == AW'(RING_WORDS - 1)) begin
			idx_next = '0;
		end else begin
			idx_next = idx_q + 1'b1;
		end
	end

	assign drain_go = accept && (req.op == OP_DRAIN) && (cons_q != prod_q)
		&& (prog_q == prod_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			CTRL_IDLE: begin
				if (drain_go) begin
					state_d = CTRL_DRAIN;
				end
			end
			CTRL_DRAIN: begin
				if (stat.read_room && cnt_q == (AW + 1)'(1)) begin
					state_d = CTRL_IDLE;
				end
			end
			default: state_d = CTRL_IDLE;
		endcase
	end

	always_comb begin
		single_valid         = accept && !drain_go;
		single.status        = ST_PROTO;
		single.word_out      = '0;
		single.last          = 1'b1;
		single.drained_bytes = '0;
		mem_we               = 1'b0;
		mem_waddr            = prod_q;
		mem_wdata            = 64'(req_bytes);
		mem_re               = 1'b0;
		mem_raddr            = idx_q;
		rd.issue             = 1'b0;
		rd.last              = (cnt_q == (AW + 1)'(1));
		rd.drained_bytes     = bytes_q;
		case (state_q)
			CTRL_IDLE: begin
				case (req.op)
					OP_BEGIN: begin
						if (!open_q) begin
							single.status = no_room ? ST_NOROOM : ST_OK;
							mem_we        = accept && !no_room;
						end
					end
					OP_PAYLOAD: begin
						if (open_q) begin
							single.status = ST_OK;
							mem_we        = accept;
							mem_waddr     = AW'(slot8);
							mem_wdata     = masked;
						end
					end
					OP_DRAIN: begin
						if (cons_q == prod_q) begin
							single.status = ST_EMPTY;
						end else if (prog_q != prod_q) begin
							single.status = ST_NOTREADY;
						end
					end
					default: single.status = ST_PROTO;
				endcase
			end
			CTRL_DRAIN: begin
				rd.issue = stat.read_room;
				mem_re   = stat.read_room;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CTRL_IDLE;
			prod_q    <= '0;
			cons_q    <= '0;
			prog_q    <= '0;
			idx_q     <= '0;
			open_q    <= 1'b0;
			rem_q     <= '0;
			cnt_q     <= '0;
			bytes_q   <= '0;
			max_adv_q <= MAX_ADVANCE_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				max_adv_q <= cfg_data;
			end
			if (accept) begin
				case (req.op)
					OP_BEGIN: begin
						if (!open_q && !no_room) begin
							prod_q <= prod_new;
							if (req.payload_bytes == '0) begin
								prog_q <= prod_new;
							end else begin
								open_q <= 1'b1;
								rem_q  <= req.payload_bytes;
							end
						end
					end
					OP_PAYLOAD: begin
						if (open_q) begin
							rem_q <= rem_new;
							if (rem_new == '0) begin
								open_q <= 1'b0;
								prog_q <= prod_q;
							end
						end
					end
					default: ;
				endcase
			end
			if (drain_go) begin
				idx_q   <= cons_q;
				cnt_q   <= count;
				bytes_q <= count_bytes[8:0];
				cons_q  <= prog_q;
			end else if (mem_re) begin
				idx_q <= idx_next;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: dv/tb_variable_length_request_ring.sv
// tb_variable_length_request_ring: self-checking bench for the framed request ring
// runs directed, limit and random traffic against a shadow ring model
// depends on vlrr_pkg and variable_length_request_ring
`timescale 1ns / 1ps

module tb_variable_length_request_ring;
	import vlrr_pkg::*;

	localparam int RING_BYTES = 512;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_item_t            req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_item_t            rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data = '0;

	// shadow copy of the ring
	logic [WORD_W-1:0]    shadow_words [64];
	logic [5:0]           wr_ptr = '0;
	logic [5:0]           rd_ptr = '0;
	logic [5:0]           commit_ptr = '0;
	bit                   open_req = 1'b0;
	logic [PLEN_W-1:0]    open_bytes = '0;
	logic [CFG_W-1:0]     advance_limit = MAX_ADVANCE_RESET;

	rsp_item_t            awaited_results [$];
	rsp_item_t            want_rsp;
	bit                   no_gaps = 1'b0;
	int unsigned          sent_items = 0;
	int unsigned          checked_count = 0;
	int unsigned          word_count = 0;
	int unsigned          limits_used = 1;
	int unsigned          fail_count = 0;
	int unsigned          cycle_count = 0;

	variable_length_request_ring #(
		.RING_BYTES(RING_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int unsigned draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [PLEN_W-1:0] pick_length();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return PLEN_W'($urandom_range(0, 48));
		if (roll < 9)
			return PLEN_W'($urandom_range(0, 504));
		return PLEN_W'($urandom_range(0, 511));
	endfunction

	// works out the results of one accepted item and advances the shadow ring
	task automatic predict_ring_results(input req_item_t item);
		rsp_item_t r;
		logic [5:0] span;
		logic [5:0] slot;
		logic [WORD_W-1:0] word;
		int unsigned used, need, count, k;
		r = '0;
		r.last = 1'b1;
		case (item.op)
			OP_BEGIN: begin
				span = wr_ptr - rd_ptr;
				used = span * 8;
				need = ((int'(item.payload_bytes) + 15) / 8) * 8;
				if (open_req) begin
					r.status = ST_PROTO;
				end else if (used + need >= advance_limit || need > RING_BYTES - used) begin
					r.status = ST_NOROOM;
				end else begin
					shadow_words[wr_ptr] = WORD_W'(need);
					wr_ptr = wr_ptr + 6'(need / 8);
					if (item.payload_bytes == 0) begin
						commit_ptr = wr_ptr;
					end else begin
						open_req = 1'b1;
						open_bytes = item.payload_bytes;
					end
					r.status = ST_OK;
				end
			end
			OP_PAYLOAD: begin
				if (!open_req) begin
					r.status = ST_PROTO;
				end else begin
					// reserved slots are filled in order behind the producer
					slot = wr_ptr - 6'((int'(open_bytes) + 7) / 8);
					if (open_bytes < 8) begin
						word = item.data_word & ((64'd1 << (open_bytes * 8)) - 64'd1);
						open_bytes = '0;
					end else begin
						word = item.data_word;
						open_bytes = open_bytes - 9'd8;
					end
					shadow_words[slot] = word;
					if (open_bytes == 0) begin
						open_req = 1'b0;
						commit_ptr = wr_ptr;
					end
					r.status = ST_OK;
				end
			end
			OP_DRAIN: begin
				if (rd_ptr == wr_ptr) begin
					r.status = ST_EMPTY;
				end else if (commit_ptr != wr_ptr) begin
					r.status = ST_NOTREADY;
				end else begin
					span = commit_ptr - rd_ptr;
					count = (span == 0) ? 64 : span;
					for (k = 0; k < count; k++) begin
						r.status = ST_WORD;
						r.word_out = shadow_words[6'(rd_ptr + k)];
						r.last = (k + 1 == count);
						r.drained_bytes = BYTES_W'(count * 8);
						awaited_results.push_back(r);
					end
					rd_ptr = commit_ptr;
					return;
				end
			end
			default: begin
				r.status = ST_PROTO;
			end
		endcase
		awaited_results.push_back(r);
	endtask

	task automatic send_item(input logic [1:0] op, input logic [PLEN_W-1:0] plen,
			input logic [WORD_W-1:0] data);
		int unsigned gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.op = op;
		req.payload_bytes = plen;
		req.data_word = data;
		req_valid = 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_ring_results(req);
		sent_items++;
	endtask

	// sends payload words until the open request commits; at word cut an
	// out-of-order item breaks into the sequence
	task automatic fill_open_request(input int cut);
		int k;
		logic [1:0] stray_op;
		k = 0;
		while (open_req) begin
			if (k == cut) begin
				case ($urandom_range(0, 2))
					0: stray_op = OP_BEGIN;
					1: stray_op = OP_DRAIN;
					default: stray_op = OP_UNUSED;
				endcase
				send_item(stray_op, pick_length(), rand_word());
			end
			send_item(OP_PAYLOAD, PLEN_W'($urandom), rand_word());
			k++;
		end
	endtask

	task automatic send_request(input logic [PLEN_W-1:0] plen, input bit broken);
		send_item(OP_BEGIN, plen, rand_word());
		fill_open_request(broken ? $urandom_range(0, (int'(plen) + 7) / 8) : -1);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_data = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		advance_limit = value;
		limits_used++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic check_field(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h got %h", $time, what, want, got);
			fail_count++;
		end
	endtask

	// protocol errors, empty and not-ready drains, header-only request, no-room begins
	task automatic test_directed_cases();
		send_item(OP_DRAIN, '0, '0);
		send_item(OP_PAYLOAD, '1, '1);
		send_item(OP_UNUSED, '1, '1);
		send_item(OP_BEGIN, '0, '1);
		send_item(OP_DRAIN, '1, '1);
		send_item(OP_BEGIN, 9'd511, '0);
		send_item(OP_BEGIN, 9'd504, '0);
		send_item(OP_BEGIN, 9'd13, '0);
		send_item(OP_DRAIN, '0, '0);
		send_item(OP_BEGIN, 9'd5, '0);
		send_item(OP_PAYLOAD, '0, '1);
		send_item(OP_PAYLOAD, '1, '1);
		send_item(OP_DRAIN, '0, '0);
		send_item(OP_BEGIN, 9'd1, '0);
		send_item(OP_PAYLOAD, '0, '1);
		send_item(OP_BEGIN, 9'd8, '0);
		send_item(OP_PAYLOAD, '0, 64'h0123_4567_89ab_cdef);
		send_item(OP_DRAIN, '0, '0);
		send_item(OP_DRAIN, '0, '0);
	endtask

	// limit 8 refuses every begin; limit 64 checks the strict compare
	task automatic test_refusing_limit();
		write_limit(CFG_W'(8));
		send_item(OP_BEGIN, '0, '0);
		send_item(OP_BEGIN, 9'd1, '0);
		send_item(OP_DRAIN, '0, '0);
		write_limit(CFG_W'(64));
		send_request(9'd48, 1'b0);
		send_item(OP_BEGIN, '0, '0);
		send_item(OP_DRAIN, '0, '0);
		send_request(9'd47, 1'b0);
		send_item(OP_DRAIN, '0, '0);
	endtask

	// with the limit above the ring size one request fills the ring exactly,
	// after which the ring reads as empty
	task automatic test_full_ring();
		write_limit('1);
		send_request(9'd504, 1'b0);
		send_item(OP_DRAIN, '0, '0);
		send_request(9'd0, 1'b0);
		send_item(OP_DRAIN, '0, '0);
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] limits [5];
		int unsigned phase, target, pick;
		limits[0] = MAX_ADVANCE_RESET;
		limits[1] = CFG_W'($urandom_range(8, 1023));
		limits[2] = CFG_W'(520);
		limits[3] = '1;
		limits[4] = CFG_W'($urandom_range(8, 300));
		for (phase = 0; phase < 5; phase++) begin
			write_limit(limits[phase]);
			no_gaps = (phase == 3);
			target = sent_items + 12;
			while (sent_items < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					send_request(pick_length(), $urandom_range(0, 9) == 0);
				end else if (pick < 85) begin
					send_item(OP_DRAIN, PLEN_W'($urandom), rand_word());
				end else begin
					send_item(2'($urandom), PLEN_W'($urandom), rand_word());
					fill_open_request(-1);
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// result side stalls at random before each transfer
	initial begin
		int unsigned stall;
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				rsp_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready = 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none got status %0d word %h",
					$time, rsp.status, rsp.word_out);
				fail_count++;
			end else begin
				want_rsp = awaited_results.pop_front();
				check_field("status", want_rsp.status, rsp.status);
				check_field("word_out", want_rsp.word_out, rsp.word_out);
				check_field("last", want_rsp.last, rsp.last);
				check_field("drained_bytes", want_rsp.drained_bytes, rsp.drained_bytes);
				checked_count++;
				if (want_rsp.status == ST_WORD)
					word_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_directed_cases();
		test_refusing_limit();
		test_full_ring();
		test_random_traffic();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("sent %0d request items across %0d limit settings", sent_items, limits_used);
		$display("checked %0d results, %0d of them drained ring words",
			checked_count, word_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
hdl/vlrr_pkg.sv
hdl/vlrr_ring_mem.sv
hdl/vlrr_out_buf.sv
hdl/vlrr_ctrl.sv
hdl/variable_length_request_ring.sv
dv/tb_variable_length_request_ring.sv
